FILE: rtl/core/rhr_pkg.sv
// rhr_pkg: shared constants, configuration indexes and sideband types
// for the rgb hue rotate / value scale pipeline. No dependencies.
package rhr_pkg;

    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int SECTOR  = 960;            // 60 degrees in 1/16 degree
    localparam int TURN    = 6 * SECTOR;
    localparam int HUE_W   = 13;
    localparam int POS_W   = 10;
    localparam int OFS_W   = 14;
    localparam int SCALE_W = 10;
    localparam int CFG_W   = 14;
    localparam int PROD_W  = CH_W + SCALE_W;

    // divider operand widths
    localparam int HNUM_W = 22;
    localparam int HDEN_W = CH_W + 1;
    localparam int MNUM_W = 27;
    localparam int MDEN_W = 19;
    localparam int LNUM_W = 17;
    localparam int LDEN_W = CH_W + 1;

    localparam logic [0:0] CFG_HUE_OFFSET  = 1'b0;
    localparam logic [0:0] CFG_VALUE_SCALE = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd256;

    typedef logic [2:0] t_sector;

    typedef struct packed {
        logic [CH_W-1:0] v;
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] mn;
        logic [CH_W-1:0] dlt;
        logic            grey;
    } t_hue_side;

    typedef struct packed {
        logic [CH_W-1:0] v;
        logic            grey;
    } t_mid_side;

endpackage

FILE: rtl/core/rhr_div.sv
// rhr_div: pipelined restoring divider, one quotient bit per stage,
// with a sideband word carried alongside. Standalone, no package use.
module rhr_div #(
    parameter int NUM_W  = 22,
    parameter int DEN_W  = 9,
    parameter int Q_W    = 13,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0] o_side
);

    localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic              r_vld  [Q_W];
    logic [W-1:0]      r_rem  [Q_W];
    logic [DEN_W-1:0]  r_den  [Q_W];
    logic [Q_W-1:0]    r_quo  [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];

    logic              w_vld  [Q_W];
    logic [W-1:0]      w_rem  [Q_W];
    logic [DEN_W-1:0]  w_den  [Q_W];
    logic [Q_W-1:0]    w_quo  [Q_W];
    logic [SIDE_W-1:0] w_side [Q_W];

    logic [W-1:0]      n_rem  [Q_W];
    logic [Q_W-1:0]    n_quo  [Q_W];

    genvar gs;
    for (gs = 0; gs < Q_W; gs++) begin : g_in
        if (gs == 0) begin : g_first
            assign w_vld[gs]  = i_valid;
            assign w_rem[gs]  = W'(i_num);
            assign w_den[gs]  = i_den;
            assign w_quo[gs]  = '0;
            assign w_side[gs] = i_side;
        end else begin : g_next
            assign w_vld[gs]  = r_vld[gs-1];
            assign w_rem[gs]  = r_rem[gs-1];
            assign w_den[gs]  = r_den[gs-1];
            assign w_quo[gs]  = r_quo[gs-1];
            assign w_side[gs] = r_side[gs-1];
        end
    end

    always_comb begin
        logic [W-1:0] dsh;
        logic         ge;
        for (int s = 0; s < Q_W; s++) begin
            dsh = W'(w_den[s]) << (Q_W - 1 - s);
            ge  = (w_rem[s] >= dsh);
            n_rem[s] = ge ? (w_rem[s] - dsh) : w_rem[s];
            n_quo[s] = w_quo[s];
            n_quo[s][Q_W-1-s] = ge;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < Q_W; s++) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld[s];
            end
            r_rem[s]  <= n_rem[s];
            r_den[s]  <= w_den[s];
            r_quo[s]  <= n_quo[s];
            r_side[s] <= w_side[s];
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

FILE: rtl/core/rhr_hsv.sv
// rhr_hsv: front pipeline, max/min/delta, scaled value and hue dividend.
// Depends on rhr_pkg. Four register stages.
module rhr_hsv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [rhr_pkg::PIX_W-1:0]     i_pixel,
    input  logic [rhr_pkg::SCALE_W-1:0]   i_scale,
    output logic                          o_valid,
    output logic [rhr_pkg::HNUM_W-1:0]    o_num,
    output logic [rhr_pkg::HDEN_W-1:0]    o_den,
    output rhr_pkg::t_hue_side            o_side
);

    localparam int CW = rhr_pkg::CH_W;

    // stage 1: capture
    logic                      r_s1_vld;
    logic [rhr_pkg::PIX_W-1:0] r_s1_pix;

    // stage 2: extremes and hue difference
    logic                 r_s2_vld;
    logic [CW-1:0]        r_s2_mx, r_s2_mn, r_s2_dlt;
    logic signed [CW:0]   r_s2_diff;
    logic [2:0]           r_s2_base;
    logic [CW-1:0]        n_s2_mx, n_s2_mn;
    logic signed [CW:0]   n_s2_diff;
    logic [2:0]           n_s2_base;

    // stage 3: product and dividend
    logic                        r_s3_vld;
    logic [rhr_pkg::PROD_W-1:0]  r_s3_prod;
    logic [rhr_pkg::HNUM_W-1:0]  r_s3_num;
    logic [CW-1:0]               r_s3_mx, r_s3_mn, r_s3_dlt;
    logic [rhr_pkg::HNUM_W-1:0]  n_s3_num;
    logic [CW+2:0]               n_bd;
    logic signed [CW+4:0]        n_hsum;

    // stage 4 outputs
    logic                        r_vld;
    logic [rhr_pkg::HNUM_W-1:0]  r_num;
    logic [rhr_pkg::HDEN_W-1:0]  r_den;
    rhr_pkg::t_hue_side          r_side;
    logic [rhr_pkg::PROD_W:0]    n_rnd;
    logic [CW-1:0]               n_v;

    always_comb begin
        logic [CW-1:0] r, g, b;
        r = r_s1_pix[2*CW +: CW];
        g = r_s1_pix[CW +: CW];
        b = r_s1_pix[0 +: CW];
        n_s2_mn = r;
        if (g < n_s2_mn) n_s2_mn = g;
        if (b < n_s2_mn) n_s2_mn = b;
        // red wins ties, then green
        if (r >= g && r >= b) begin
            n_s2_mx   = r;
            n_s2_diff = $signed({1'b0, g}) - $signed({1'b0, b});
            n_s2_base = (g < b) ? 3'd6 : 3'd0;
        end else if (g >= b) begin
            n_s2_mx   = g;
            n_s2_diff = $signed({1'b0, b}) - $signed({1'b0, r});
            n_s2_base = 3'd2;
        end else begin
            n_s2_mx   = b;
            n_s2_diff = $signed({1'b0, r}) - $signed({1'b0, g});
            n_s2_base = 3'd4;
        end
    end

    // hue numerator is (diff + base*delta)*2*sector + delta, never negative
    always_comb begin
        n_bd     = (CW+3)'(r_s2_base) * (CW+3)'(r_s2_dlt);
        n_hsum   = $signed({2'b00, n_bd}) + (CW+5)'(r_s2_diff);
        n_s3_num = rhr_pkg::HNUM_W'(n_hsum[CW+2:0]) * rhr_pkg::HNUM_W'(2 * rhr_pkg::SECTOR)
                 + rhr_pkg::HNUM_W'(r_s2_dlt);
    end

    always_comb begin
        n_rnd = (rhr_pkg::PROD_W+1)'(r_s3_prod) + (rhr_pkg::PROD_W+1)'(128);
        if (n_rnd[rhr_pkg::PROD_W:8] > (rhr_pkg::PROD_W-7)'({CW{1'b1}})) begin
            n_v = {CW{1'b1}};
        end else begin
            n_v = n_rnd[CW+7:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_vld    <= r_s3_vld;
        end
        r_s1_pix  <= i_pixel;
        r_s2_mx   <= n_s2_mx;
        r_s2_mn   <= n_s2_mn;
        r_s2_dlt  <= n_s2_mx - n_s2_mn;
        r_s2_diff <= n_s2_diff;
        r_s2_base <= n_s2_base;
        r_s3_prod <= rhr_pkg::PROD_W'(r_s2_mx) * rhr_pkg::PROD_W'(i_scale);
        r_s3_num  <= n_s3_num;
        r_s3_mx   <= r_s2_mx;
        r_s3_mn   <= r_s2_mn;
        r_s3_dlt  <= r_s2_dlt;
        r_num       <= r_s3_num;
        r_den       <= {r_s3_dlt, 1'b0};
        r_side.v    <= n_v;
        r_side.mx   <= r_s3_mx;
        r_side.mn   <= r_s3_mn;
        r_side.dlt  <= r_s3_dlt;
        r_side.grey <= (r_s3_dlt == '0);
    end

    assign o_valid = r_vld;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

FILE: rtl/core/rhr_rgb.sv
// rhr_rgb: hue rotation, sector split and the channel dividends.
// Depends on rhr_pkg. Five register stages.
module rhr_rgb (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [rhr_pkg::HUE_W-1:0]         i_hue,
    input  rhr_pkg::t_hue_side                i_side,
    input  logic signed [rhr_pkg::OFS_W-1:0]  i_offset,
    output logic                              o_valid,
    output logic [rhr_pkg::MNUM_W-1:0]        o_mid_num,
    output logic [rhr_pkg::MDEN_W-1:0]        o_mid_den,
    output logic [rhr_pkg::LNUM_W-1:0]        o_lo_num,
    output logic [rhr_pkg::LDEN_W-1:0]        o_lo_den,
    output rhr_pkg::t_mid_side                o_mid_side,
    output rhr_pkg::t_sector                  o_sector
);

    localparam int CW  = rhr_pkg::CH_W;
    localparam int HW  = rhr_pkg::HUE_W;
    localparam int TW  = HW + 2;
    localparam int PW  = rhr_pkg::POS_W;

    // stage 1: hue plus offset, biased by two turns
    logic                 r_s1_vld;
    logic [TW-1:0]        r_s1_t;
    rhr_pkg::t_hue_side   r_s1_side;
    logic [HW-1:0]        n_h;
    logic signed [TW:0]   n_t;

    // stage 2: reduced hue
    logic                 r_s2_vld;
    logic [HW-1:0]        r_s2_h;
    rhr_pkg::t_hue_side   r_s2_side;
    logic [HW-1:0]        n_s2_h;

    // stage 3: sector and position
    logic                 r_s3_vld;
    rhr_pkg::t_sector     r_s3_sec;
    logic [PW-1:0]        r_s3_pos;
    rhr_pkg::t_hue_side   r_s3_side;
    rhr_pkg::t_sector     n_s3_sec;
    logic [PW-1:0]        n_s3_pos;

    // stage 4: products
    logic                 r_s4_vld;
    logic [2*CW-1:0]      r_s4_a, r_s4_b;
    logic [PW-1:0]        r_s4_pos;
    logic [CW-1:0]        r_s4_mx;
    rhr_pkg::t_sector     r_s4_sec;
    rhr_pkg::t_mid_side   r_s4_ms;

    // stage 5 outputs
    logic                         r_vld;
    logic [rhr_pkg::MNUM_W-1:0]   r_mid_num;
    logic [rhr_pkg::MDEN_W-1:0]   r_mid_den;
    logic [rhr_pkg::LNUM_W-1:0]   r_lo_num;
    logic [rhr_pkg::LDEN_W-1:0]   r_lo_den;
    rhr_pkg::t_mid_side           r_ms;
    rhr_pkg::t_sector             r_sec;

    always_comb begin
        // a rounded hue of a full turn wraps to zero
        n_h = (i_hue >= HW'(rhr_pkg::TURN)) ? (i_hue - HW'(rhr_pkg::TURN)) : i_hue;
        n_t = $signed({3'b000, n_h}) + (TW+1)'(i_offset) + (TW+1)'(2 * rhr_pkg::TURN);
    end

    always_comb begin
        n_s2_h = HW'(r_s1_t);
        for (int k = 1; k <= 4; k++) begin
            if (r_s1_t >= TW'(k * rhr_pkg::TURN)) begin
                n_s2_h = HW'(r_s1_t - TW'(k * rhr_pkg::TURN));
            end
        end
    end

    always_comb begin
        logic [HW-1:0] base;
        base     = '0;
        n_s3_sec = '0;
        for (int k = 1; k <= 5; k++) begin
            if (r_s2_h >= HW'(k * rhr_pkg::SECTOR)) begin
                n_s3_sec = 3'(k);
                base     = HW'(k * rhr_pkg::SECTOR);
            end
        end
        n_s3_pos = PW'(r_s2_h - base);
        // odd sectors count down
        if (n_s3_sec[0]) n_s3_pos = PW'(rhr_pkg::SECTOR) - n_s3_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_vld    <= r_s4_vld;
        end
        r_s1_t    <= n_t[TW-1:0];
        r_s1_side <= i_side;
        r_s2_h    <= n_s2_h;
        r_s2_side <= r_s1_side;
        r_s3_sec  <= n_s3_sec;
        r_s3_pos  <= n_s3_pos;
        r_s3_side <= r_s2_side;
        r_s4_a    <= (2*CW)'(r_s3_side.v) * (2*CW)'(r_s3_side.mn);
        r_s4_b    <= (2*CW)'(r_s3_side.v) * (2*CW)'(r_s3_side.dlt);
        r_s4_pos  <= r_s3_pos;
        r_s4_mx   <= r_s3_side.mx;
        r_s4_sec  <= r_s3_sec;
        r_s4_ms.v    <= r_s3_side.v;
        r_s4_ms.grey <= r_s3_side.grey;
        // mid = round((v*mn*sector + v*delta*pos) / (mx*sector))
        r_mid_num <= rhr_pkg::MNUM_W'(r_s4_a) * rhr_pkg::MNUM_W'(2 * rhr_pkg::SECTOR)
                   + rhr_pkg::MNUM_W'({(2*CW+PW)'(r_s4_b) * (2*CW+PW)'(r_s4_pos), 1'b0})
                   + rhr_pkg::MNUM_W'(r_s4_mx) * rhr_pkg::MNUM_W'(rhr_pkg::SECTOR);
        r_mid_den <= rhr_pkg::MDEN_W'(r_s4_mx) * rhr_pkg::MDEN_W'(2 * rhr_pkg::SECTOR);
        // lo = round(v*mn / mx)
        r_lo_num  <= rhr_pkg::LNUM_W'({r_s4_a, 1'b0}) + rhr_pkg::LNUM_W'(r_s4_mx);
        r_lo_den  <= {r_s4_mx, 1'b0};
        r_ms      <= r_s4_ms;
        r_sec     <= r_s4_sec;
    end

    assign o_valid    = r_vld;
    assign o_mid_num  = r_mid_num;
    assign o_mid_den  = r_mid_den;
    assign o_lo_num   = r_lo_num;
    assign o_lo_den   = r_lo_den;
    assign o_mid_side = r_ms;
    assign o_sector   = r_sec;

endmodule

FILE: rtl/core/rgb_hue_rotate_value_scale_top.sv
// rgb_hue_rotate_value_scale_top: top level, configuration registers,
// dividers and output packing. Depends on rhr_pkg, rhr_hsv, rhr_rgb, rhr_div.
//
// Takes one pixel per clock on start and returns the rotated, value scaled
// pixel on o_done, one cycle wide; busy is always low and the receiver
// cannot stall. Two bit-per-stage dividers (13 stages for the hue, 8 for
// the output channels) sit with 10 stages of arithmetic around them.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must do so with the pipeline empty, the block does not enforce it.
module rgb_hue_rotate_value_scale_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rhr_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                          o_done,
    output logic [rhr_pkg::PIX_W-1:0]     o_pixel_out,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [rhr_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CW = rhr_pkg::CH_W;

    logic signed [rhr_pkg::OFS_W-1:0] r_hue_offset;
    logic [rhr_pkg::SCALE_W-1:0]      r_value_scale;

    logic                         w_h_vld;
    logic [rhr_pkg::HNUM_W-1:0]   w_h_num;
    logic [rhr_pkg::HDEN_W-1:0]   w_h_den;
    rhr_pkg::t_hue_side           w_h_side;

    logic                         w_q_vld;
    logic [rhr_pkg::HUE_W-1:0]    w_q_hue;
    rhr_pkg::t_hue_side           w_q_side;

    logic                         w_c_vld;
    logic [rhr_pkg::MNUM_W-1:0]   w_mid_num;
    logic [rhr_pkg::MDEN_W-1:0]   w_mid_den;
    logic [rhr_pkg::LNUM_W-1:0]   w_lo_num;
    logic [rhr_pkg::LDEN_W-1:0]   w_lo_den;
    rhr_pkg::t_mid_side           w_ms;
    rhr_pkg::t_sector             w_sec;

    logic                         w_mid_vld, w_lo_vld;
    logic [CW-1:0]                w_mid, w_lo;
    rhr_pkg::t_mid_side           w_ms_out;
    rhr_pkg::t_sector             w_sec_out;

    logic                         r_done;
    logic [rhr_pkg::PIX_W-1:0]    r_pixel;
    logic [rhr_pkg::PIX_W-1:0]    n_pixel;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_offset  <= '0;
            r_value_scale <= rhr_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rhr_pkg::CFG_HUE_OFFSET: begin
                    r_hue_offset <= $signed(i_cfg_data[rhr_pkg::OFS_W-1:0]);
                end
                rhr_pkg::CFG_VALUE_SCALE: begin
                    r_value_scale <= i_cfg_data[rhr_pkg::SCALE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    rhr_hsv u_hsv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_pixel (i_pixel_in),
        .i_scale (r_value_scale),
        .o_valid (w_h_vld),
        .o_num   (w_h_num),
        .o_den   (w_h_den),
        .o_side  (w_h_side)
    );

    rhr_div #(
        .NUM_W  (rhr_pkg::HNUM_W),
        .DEN_W  (rhr_pkg::HDEN_W),
        .Q_W    (rhr_pkg::HUE_W),
        .SIDE_W ($bits(rhr_pkg::t_hue_side))
    ) u_hue_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_h_vld),
        .i_num   (w_h_num),
        .i_den   (w_h_den),
        .i_side  (w_h_side),
        .o_valid (w_q_vld),
        .o_quo   (w_q_hue),
        .o_side  (w_q_side)
    );

    rhr_rgb u_rgb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_vld),
        .i_hue      (w_q_hue),
        .i_side     (w_q_side),
        .i_offset   (r_hue_offset),
        .o_valid    (w_c_vld),
        .o_mid_num  (w_mid_num),
        .o_mid_den  (w_mid_den),
        .o_lo_num   (w_lo_num),
        .o_lo_den   (w_lo_den),
        .o_mid_side (w_ms),
        .o_sector   (w_sec)
    );

    rhr_div #(
        .NUM_W  (rhr_pkg::MNUM_W),
        .DEN_W  (rhr_pkg::MDEN_W),
        .Q_W    (CW),
        .SIDE_W ($bits(rhr_pkg::t_mid_side))
    ) u_mid_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c_vld),
        .i_num   (w_mid_num),
        .i_den   (w_mid_den),
        .i_side  (w_ms),
        .o_valid (w_mid_vld),
        .o_quo   (w_mid),
        .o_side  (w_ms_out)
    );

    rhr_div #(
        .NUM_W  (rhr_pkg::LNUM_W),
        .DEN_W  (rhr_pkg::LDEN_W),
        .Q_W    (CW),
        .SIDE_W ($bits(rhr_pkg::t_sector))
    ) u_lo_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c_vld),
        .i_num   (w_lo_num),
        .i_den   (w_lo_den),
        .i_side  (w_sec),
        .o_valid (w_lo_vld),
        .o_quo   (w_lo),
        .o_side  (w_sec_out)
    );

    // place max, mid and min by sector; grey and black give v on all channels
    always_comb begin
        case (w_sec_out)
            3'd0:    n_pixel = {w_ms_out.v, w_mid, w_lo};
            3'd1:    n_pixel = {w_mid, w_ms_out.v, w_lo};
            3'd2:    n_pixel = {w_lo, w_ms_out.v, w_mid};
            3'd3:    n_pixel = {w_lo, w_mid, w_ms_out.v};
            3'd4:    n_pixel = {w_mid, w_lo, w_ms_out.v};
            default: n_pixel = {w_ms_out.v, w_lo, w_mid};
        endcase
        if (w_ms_out.grey) n_pixel = {w_ms_out.v, w_ms_out.v, w_ms_out.v};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_mid_vld && w_lo_vld;
        end
        r_pixel <= n_pixel;
    end

    assign o_done      = r_done;
    assign o_pixel_out = r_pixel;

endmodule

FILE: rtl/core/rhr_chk.sv
// rhr_chk: port-level checker for rgb_hue_rotate_value_scale_top and
// its bind. Depends on rhr_pkg.
module rhr_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [rhr_pkg::PIX_W-1:0] i_pixel_in,
    input logic                      o_done,
    input logic [rhr_pkg::PIX_W-1:0] o_pixel_out
);

    localparam int LAT = 31;
    localparam int CW  = rhr_pkg::CH_W;

    // every accepted transfer comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("accepted pixel did not produce a result");

    // no result without a matching transfer
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without an accepted pixel");

    // black stays black
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_pixel_in == '0) |-> ##LAT (o_pixel_out == '0))
        else $error("black input gave a colored result");

    // grey stays grey
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_pixel_in[2*CW +: CW] == i_pixel_in[CW +: CW]
            && i_pixel_in[CW +: CW] == i_pixel_in[0 +: CW])
        |-> ##LAT (o_pixel_out[2*CW +: CW] == o_pixel_out[CW +: CW]
            && o_pixel_out[CW +: CW] == o_pixel_out[0 +: CW]))
        else $error("grey input gave a colored result");

endmodule

bind rgb_hue_rotate_value_scale_top rhr_chk u_rhr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_pixel_in  (i_pixel_in),
    .o_done      (o_done),
    .o_pixel_out (o_pixel_out)
);
